// ===== hdl/ktes_pkg.sv =====
// Package for the k-truss edge support checker.
// Holds sizes, field codes, the beat structs and the controller/datapath links.
// No dependencies.
package ktes_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 8192;

    localparam int NODE_W   = 10;
    localparam int OFS_W    = 14;
    localparam int CNT_W    = 14;
    localparam int TRUSS_W  = 11;
    localparam int ROW_AW   = $clog2(MAX_NODES + 1);
    localparam int EDGE_AW  = $clog2(MAX_EDGES);
    localparam int ENTRY_W  = NODE_W + 1;

    localparam logic [1:0] KIND_ROW   = 2'd0;
    localparam logic [1:0] KIND_EDGE  = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;

    localparam logic [1:0] VERD_OK             = 2'd0;
    localparam logic [1:0] VERD_SHOULD_INVALID = 2'd1;
    localparam logic [1:0] VERD_SHOULD_VALID   = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [13:0]       slot;
        logic [13:0]       value;
        logic              mark;
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
    } req_t;

    typedef struct packed {
        logic [1:0]         verdict;
        logic               support_enough;
        logic               edge_removed;
        logic               edge_missing;
        logic [TRUSS_W-1:0] common_found;
    } rsp_t;

    typedef struct packed {
        logic load_item;
        logic clr_wr;
        logic row_sel_dst;
        logic ld_src_bnd;
        logic ld_dst_bnd;
        logic mrg_step;
        logic lkp_init;
        logic lkp_step;
        logic out_load;
    } ktes_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic mrg_done;
        logic lkp_done;
        logic out_free;
    } ktes_stat_t;

endpackage

// ===== hdl/ktes_ctrl.sv =====
// Controller for the k-truss edge support checker: sequences clear, loads,
// row bound fetch, row merge, edge lookup and result hand-off.
// Depends on ktes_pkg.
module ktes_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic [1:0]             req_kind,
    input  ktes_pkg::ktes_stat_t   stat,
    output ktes_pkg::ktes_cmd_t    cmd,
    output logic                   req_stall
);
    import ktes_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHK_SRC,
        ST_CHK_DST,
        ST_CHK_DLD,
        ST_MRG_FETCH,
        ST_MRG_CMP,
        ST_LKP_INIT,
        ST_LKP_FETCH,
        ST_LKP_CMP,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (req_kind == KIND_CHECK)
                        state_next = ST_CHK_SRC;
                end
            end
            ST_CHK_SRC:
                state_next = ST_CHK_DST;
            ST_CHK_DST:
            begin
                cmd.row_sel_dst = 1'b1;
                cmd.ld_src_bnd  = 1'b1;
                state_next      = ST_CHK_DLD;
            end
            ST_CHK_DLD:
            begin
                cmd.ld_dst_bnd = 1'b1;
                state_next     = ST_MRG_FETCH;
            end
            ST_MRG_FETCH:
                state_next = ST_MRG_CMP;
            ST_MRG_CMP:
            begin
                cmd.mrg_step = 1'b1;
                state_next   = stat.mrg_done ? ST_LKP_INIT : ST_MRG_FETCH;
            end
            ST_LKP_INIT:
            begin
                cmd.lkp_init = 1'b1;
                state_next   = ST_LKP_FETCH;
            end
            ST_LKP_FETCH:
                state_next = ST_LKP_CMP;
            ST_LKP_CMP:
            begin
                cmd.lkp_step = 1'b1;
                state_next   = stat.lkp_done ? ST_RESULT : ST_LKP_FETCH;
            end
            ST_RESULT:
            begin
                // hold until the output register can take the beat
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

// ===== hdl/ktes_dpath.sv =====
// Datapath for the k-truss edge support checker: row offset and edge stores,
// merge and lookup pointers, common-neighbor counter, config and output register.
// Depends on ktes_pkg.
module ktes_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ktes_pkg::req_t                req,
    input  logic                          cfg_valid,
    input  logic [ktes_pkg::TRUSS_W-1:0]  cfg_data,
    input  logic                          rsp_stall,
    input  ktes_pkg::ktes_cmd_t           cmd,
    output ktes_pkg::ktes_stat_t          stat,
    output ktes_pkg::rsp_t                rsp,
    output logic                          rsp_valid
);
    import ktes_pkg::*;

    // stores
    logic [OFS_W-1:0]   row_mem  [0:MAX_NODES];
    logic [ENTRY_W-1:0] edge_mem [0:MAX_EDGES-1];

    logic [OFS_W-1:0]   rs0_reg, rs1_reg;
    logic [ENTRY_W-1:0] rd_a_reg, rd_b_reg;

    logic [NODE_W-1:0]  src_reg, src_next, dst_reg, dst_next;
    logic [OFS_W-1:0]   si_reg, si_next, se_reg, se_next;
    logic [OFS_W-1:0]   di_reg, di_next, de_reg, de_next;
    logic [OFS_W-1:0]   src_lo_reg, src_lo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               enough_reg, enough_next;
    logic               rem_reg, rem_next;
    logic               miss_reg, miss_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [TRUSS_W-1:0] truss_reg;
    logic [EDGE_AW-1:0] clr_cnt_reg;

    logic [NODE_W-1:0]  row_node;
    logic [ROW_AW-1:0]  row_addr0, row_addr1;
    logic               row_we;
    logic               edge_we;
    logic [EDGE_AW-1:0] edge_waddr;
    logic [ENTRY_W-1:0] edge_wdata;

    logic [OFS_W-1:0]   hi_c, lo_c;
    logic [TRUSS_W-1:0] thr;
    logic [CNT_W-1:0]   cnt_inc;
    logic               a_rem, b_rem;
    logic [NODE_W-1:0]  a_id, b_id;
    logic               mrg_exh, both_match, cnt_hit, lkp_exh, lkp_hit;
    logic               verd_rem, verd_enough;

    // store access
    assign row_node  = cmd.row_sel_dst ? dst_reg : src_reg;
    assign row_addr0 = {1'b0, row_node};
    assign row_addr1 = {1'b0, row_node} + ROW_AW'(1);
    assign row_we    = cmd.load_item && (req.kind == KIND_ROW)
                       && (req.slot <= 14'(MAX_NODES));

    always_comb
    begin
        edge_we    = 1'b0;
        edge_waddr = req.slot[EDGE_AW-1:0];
        edge_wdata = {req.mark, req.value[NODE_W-1:0]};
        if (cmd.clr_wr)
        begin
            // reset sweep: every entry starts out removed
            edge_we    = 1'b1;
            edge_waddr = clr_cnt_reg;
            edge_wdata = {1'b1, {NODE_W{1'b0}}};
        end
        else if (cmd.load_item && (req.kind == KIND_EDGE)
                 && (req.slot < 14'(MAX_EDGES)))
        begin
            edge_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[req.slot[ROW_AW-1:0]] <= req.value;
        rs0_reg <= row_mem[row_addr0];
        rs1_reg <= row_mem[row_addr1];
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_waddr] <= edge_wdata;
        rd_a_reg <= edge_mem[si_reg[EDGE_AW-1:0]];
        rd_b_reg <= edge_mem[di_reg[EDGE_AW-1:0]];
    end

    // row bounds: clamp end to the store depth, start to the end
    assign hi_c = (rs1_reg > OFS_W'(MAX_EDGES)) ? OFS_W'(MAX_EDGES) : rs1_reg;
    assign lo_c = (rs0_reg > hi_c) ? hi_c : rs0_reg;

    assign thr     = (truss_reg >= TRUSS_W'(2)) ? truss_reg - TRUSS_W'(2) : '0;
    assign cnt_inc = cnt_reg + CNT_W'(1);

    assign a_rem = rd_a_reg[ENTRY_W-1];
    assign b_rem = rd_b_reg[ENTRY_W-1];
    assign a_id  = rd_a_reg[NODE_W-1:0];
    assign b_id  = rd_b_reg[NODE_W-1:0];

    assign mrg_exh    = (si_reg == se_reg) || (di_reg == de_reg);
    assign both_match = !a_rem && !b_rem && (a_id == b_id);
    assign cnt_hit    = (cnt_inc >= CNT_W'(thr));
    assign lkp_exh    = (si_reg == se_reg);
    assign lkp_hit    = (a_id == dst_reg);

    assign stat.clr_last = (clr_cnt_reg == {EDGE_AW{1'b1}});
    assign stat.mrg_done = mrg_exh || (both_match && cnt_hit);
    assign stat.lkp_done = lkp_exh || lkp_hit;
    assign stat.out_free = !rsp_valid_reg || !rsp_stall;

    assign verd_rem    = rem_reg;
    assign verd_enough = enough_reg;

    always_comb
    begin
        src_next    = src_reg;
        dst_next    = dst_reg;
        si_next     = si_reg;
        se_next     = se_reg;
        di_next     = di_reg;
        de_next     = de_reg;
        src_lo_next = src_lo_reg;
        cnt_next    = cnt_reg;
        enough_next = enough_reg;
        rem_next    = rem_reg;
        miss_next   = miss_reg;
        rsp_next    = rsp_reg;

        if (cmd.load_item)
        begin
            src_next    = req.src_node;
            dst_next    = req.dst_node;
            cnt_next    = '0;
            enough_next = 1'b0;
        end

        if (cmd.ld_src_bnd)
        begin
            si_next     = lo_c;
            se_next     = hi_c;
            src_lo_next = lo_c;
        end

        if (cmd.ld_dst_bnd)
        begin
            di_next = lo_c;
            de_next = hi_c;
        end

        if (cmd.mrg_step)
        begin
            if (mrg_exh)
                enough_next = (cnt_reg >= CNT_W'(thr));
            else if (a_rem)
                si_next = si_reg + OFS_W'(1);
            else if (b_rem)
                di_next = di_reg + OFS_W'(1);
            else if (a_id < b_id)
                si_next = si_reg + OFS_W'(1);
            else if (b_id < a_id)
                di_next = di_reg + OFS_W'(1);
            else
            begin
                cnt_next = cnt_inc;
                if (cnt_hit)
                    enough_next = 1'b1;
                else
                begin
                    si_next = si_reg + OFS_W'(1);
                    di_next = di_reg + OFS_W'(1);
                end
            end
        end

        if (cmd.lkp_init)
            si_next = src_lo_reg;

        if (cmd.lkp_step)
        begin
            if (lkp_exh)
            begin
                miss_next = 1'b1;
                rem_next  = 1'b1;
            end
            else if (lkp_hit)
            begin
                miss_next = 1'b0;
                rem_next  = a_rem;
            end
            else
                si_next = si_reg + OFS_W'(1);
        end

        if (cmd.out_load)
        begin
            if (!verd_rem && !verd_enough)
                rsp_next.verdict = VERD_SHOULD_INVALID;
            else if (verd_rem && verd_enough)
                rsp_next.verdict = VERD_SHOULD_VALID;
            else
                rsp_next.verdict = VERD_OK;
            rsp_next.support_enough = verd_enough;
            rsp_next.edge_removed   = verd_rem;
            rsp_next.edge_missing   = miss_reg;
            rsp_next.common_found   = cnt_reg[TRUSS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        si_reg     <= si_next;
        se_reg     <= se_next;
        di_reg     <= di_next;
        de_reg     <= de_next;
        src_lo_reg <= src_lo_next;
        cnt_reg    <= cnt_next;
        enough_reg <= enough_next;
        rem_reg    <= rem_next;
        miss_reg   <= miss_next;
        rsp_reg    <= rsp_next;
    end

    // drop the beat once taken, raise it on a new result
    always_comb
    begin
        if (cmd.out_load)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            truss_reg     <= TRUSS_W'(2);
            clr_cnt_reg   <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid)
                truss_reg <= cfg_data;
            if (cmd.clr_wr)
                clr_cnt_reg <= clr_cnt_reg + EDGE_AW'(1);
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== hdl/ktruss_edge_support_check.sv =====
// K-truss edge support checker. A load beat leaves the controller idle. A
// check fetches the row bounds of src and dst, merges the two rows step by
// step, sets up the lookup, walks the src row for the dst entry and then
// hands off the result, waiting while the output beat is stalled.
// One item is in flight at a time. After rst_n the edge store is swept to
// removed, one entry a cycle over all 8192 entries, with req_stall high.
module ktruss_edge_support_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  ktes_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output ktes_pkg::rsp_t                rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ktes_pkg::TRUSS_W-1:0]  cfg_data
);
    import ktes_pkg::*;

    ktes_cmd_t  cmd;
    ktes_stat_t stat;
    logic       cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    ktes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .stat      (stat),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    ktes_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_we),
        .cfg_data  (cfg_data),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

    // a new result beat only follows a result load
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd.out_load))
        else $error("result beat raised without a load");

    // never overwrite a pending, stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(rsp_valid && rsp_stall))
        else $error("result load over a stalled beat");

    // datapath steps are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_item, cmd.clr_wr, cmd.ld_src_bnd, cmd.ld_dst_bnd,
                  cmd.mrg_step, cmd.lkp_init, cmd.lkp_step, cmd.out_load}))
        else $error("overlapping datapath commands");

    // requests are taken only when the controller issues a load
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> cmd.load_item)
        else $error("request accepted without a load command");

endmodule
